### hdl/rtlf_pkg.sv
// Shared types and constants for the record timestamp line filter.
// No dependencies; imported by every module of the block.
package rtlf_pkg;

  localparam int unsigned LINE_CAPACITY = 64;
  localparam int unsigned PREFIX_LENGTH = 5;
  localparam int unsigned ADDR_W        = $clog2(LINE_CAPACITY);
  localparam int unsigned LEN_W         = 7;
  localparam int unsigned STAMP_W       = 32;
  localparam int unsigned WIDE_W        = STAMP_W + 4;
  localparam int unsigned RADIX         = 10;

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [LEN_W-1:0] DIGIT_SAT = 7'd127;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_JUDGE,
    ST_EMIT
  } state_e;

  typedef enum logic [1:0] {
    PH_WAIT   = 2'd0,
    PH_DIGITS = 2'd1,
    PH_VALID  = 2'd2,
    PH_BAD    = 2'd3
  } phase_e;

  typedef struct packed {
    logic take;
    logic judge;
    logic load_byte;
    logic load_nl;
  } dp_cmd_t;

  typedef struct packed {
    logic term;
    logic pass;
    logic idx_done;
    logic out_free;
  } dp_status_t;

endpackage

### hdl/rtlf_ctrl.sv
// Sequencer for the line filter: takes beats, judges lines, replays kept ones.
// Depends on rtlf_pkg.
module rtlf_ctrl
  import rtlf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  state_e state_q, state_d;
  logic   take;

  assign take = in_valid_i && (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (take && status_i.term) state_d = ST_JUDGE;
      end
      ST_JUDGE: begin
        state_d = status_i.pass ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (status_i.out_free && status_i.idx_done) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o      = (state_q != ST_IDLE);
    cmd_o.take      = take;
    cmd_o.judge     = (state_q == ST_JUDGE);
    cmd_o.load_byte = (state_q == ST_EMIT) && status_i.out_free && !status_i.idx_done;
    cmd_o.load_nl   = (state_q == ST_EMIT) && status_i.out_free && status_i.idx_done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### hdl/rtlf_datapath.sv
// Line store, timestamp parser, threshold register and output register.
// Depends on rtlf_pkg; driven by rtlf_ctrl commands.
module rtlf_datapath
  import rtlf_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [STAMP_W-1:0] cfg_wdata_i,
  input  logic [7:0]         data_byte_i,
  input  logic               end_of_data_i,
  input  dp_cmd_t            cmd_i,
  output dp_status_t         status_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         out_byte_o,
  output logic               last_of_run_o
);

  logic [7:0]         mem [LINE_CAPACITY];

  logic [STAMP_W-1:0] min_q;
  logic [LEN_W-1:0]   len_q, len_d;
  logic               disc_q, disc_d;
  logic [STAMP_W-1:0] val_q, val_d;
  logic [LEN_W-1:0]   dcnt_q, dcnt_d;
  phase_e             phase_q, phase_d;

  logic [LEN_W-1:0]   emit_len_q;
  logic [LEN_W-1:0]   idx_q;
  logic               out_valid_q, out_valid_d;
  logic [7:0]         rd_data_q;
  logic               nl_q;

  logic               is_nl, is_cr, is_digit, store_wr;
  phase_e             ph_mid;
  logic [WIDE_W-1:0]  wide_val;

  assign is_nl    = (data_byte_i == CH_NL);
  assign is_cr    = (data_byte_i == CH_CR);
  assign is_digit = (data_byte_i >= CH_ZERO) && (data_byte_i <= CH_NINE);
  assign store_wr = cmd_i.take && !is_nl && !is_cr && !disc_q &&
                    (len_q < LEN_W'(LINE_CAPACITY - 1));
  assign wide_val = {{(WIDE_W-STAMP_W){1'b0}}, val_q} * WIDE_W'(RADIX) +
                    WIDE_W'(data_byte_i - CH_ZERO);

  always_comb begin
    len_d   = len_q;
    disc_d  = disc_q;
    val_d   = val_q;
    dcnt_d  = dcnt_q;
    phase_d = phase_q;
    ph_mid  = phase_q;
    if (cmd_i.judge) begin
      len_d   = '0;
      disc_d  = 1'b0;
      val_d   = '0;
      dcnt_d  = '0;
      phase_d = PH_WAIT;
    end else if (cmd_i.take && !is_nl && !is_cr && !disc_q) begin
      if (store_wr) begin
        len_d = len_q + LEN_W'(1);
        if (phase_q == PH_WAIT && len_q >= LEN_W'(PREFIX_LENGTH)) ph_mid = PH_DIGITS;
        phase_d = ph_mid;
        if (ph_mid == PH_DIGITS) begin
          if (is_digit) begin
            val_d = (wide_val[WIDE_W-1:STAMP_W] != '0) ? '1 : wide_val[STAMP_W-1:0];
            if (dcnt_q < DIGIT_SAT) dcnt_d = dcnt_q + LEN_W'(1);
          end else if (data_byte_i == CH_COMMA) begin
            phase_d = (dcnt_q != '0) ? PH_VALID : PH_BAD;
          end else begin
            phase_d = PH_BAD;
          end
        end
      end else begin
        disc_d = 1'b1;
        len_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q   <= '0;
      len_q   <= '0;
      disc_q  <= 1'b0;
      val_q   <= '0;
      dcnt_q  <= '0;
      phase_q <= PH_WAIT;
    end else begin
      if (cfg_we_i) min_q <= cfg_wdata_i;
      len_q   <= len_d;
      disc_q  <= disc_d;
      val_q   <= val_d;
      dcnt_q  <= dcnt_d;
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (store_wr) mem[len_q[ADDR_W-1:0]] <= data_byte_i;
    if (cmd_i.load_byte) rd_data_q <= mem[idx_q[ADDR_W-1:0]];
  end

  // replay counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      emit_len_q <= '0;
      idx_q      <= '0;
    end else if (cmd_i.judge) begin
      emit_len_q <= len_q;
      idx_q      <= '0;
    end else if (cmd_i.load_byte) begin
      idx_q <= idx_q + LEN_W'(1);
    end
  end

  assign out_valid_d = (cmd_i.load_byte || cmd_i.load_nl) ? 1'b1 : (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      nl_q        <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (cmd_i.load_byte || cmd_i.load_nl) nl_q <= cmd_i.load_nl;
    end
  end

  assign status_o.term     = is_nl || end_of_data_i;
  assign status_o.pass     = !disc_q && (len_q > LEN_W'(PREFIX_LENGTH)) &&
                             (phase_q == PH_VALID) && (val_q >= min_q);
  assign status_o.idx_done = (idx_q >= emit_len_q);
  assign status_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = nl_q ? CH_NL : rd_data_q;
  assign last_of_run_o = nl_q;

endmodule

### hdl/record_timestamp_line_filter_top.sv
// Record timestamp line filter, top level.
// Input channel: data_byte_i/end_of_data_i beats under in_valid_i/in_stall_o.
// Output channel: out_byte_o/last_of_run_o beats under out_valid_o/out_stall_i.
// Config: cfg_we_i writes cfg_wdata_i into the minimum timestamp register.
// An ordinary byte is taken without stalling input. A newline or
// end-of-data beat moves the rtlf_ctrl state machine to a judge state, in
// which input is stalled and the line is judged against the threshold.
// A kept line is then replayed from the line store, one beat per cycle
// (its length plus one for the closing newline), during which input is
// stalled. The emit state after judging loads the first output byte.
// The single output register lets input resume while the closing newline
// still waits. When the receiver stalls, the output beat holds and replay
// pauses; input stays stalled until replay ends.
// Reset clears the line state and the threshold (zero rejects no stamp);
// no clearing pass is needed, the block takes beats right after reset.
// Depends on rtlf_pkg, rtlf_ctrl and rtlf_datapath.
module record_timestamp_line_filter_top
  import rtlf_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [STAMP_W-1:0] cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         data_byte_i,
  input  logic               end_of_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         out_byte_o,
  output logic               last_of_run_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  rtlf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rtlf_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .data_byte_i   (data_byte_i),
    .end_of_data_i (end_of_data_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .last_of_run_o (last_of_run_o)
  );

  a_term_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (data_byte_i == CH_NL || end_of_data_i) |=> in_stall_o)
    else $error("no judge cycle after line end");

  a_plain_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && data_byte_i != CH_NL && !end_of_data_i |=> !in_stall_o)
    else $error("ordinary beat stalled input");

  a_last_is_nl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_of_run_o |-> out_byte_o == CH_NL)
    else $error("closing beat is not a newline");

  a_emit_holds_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) && !last_of_run_o |-> in_stall_o)
    else $error("input taken during replay");

endmodule

### tb/tb_record_timestamp_line_filter_top.sv
// Self-checking testbench for record_timestamp_line_filter_top.
// Feeds directed and random log lines under random idling on both channels and checks
// every forwarded beat against a line filter predictor; depends on rtlf_pkg and the DUT.
`timescale 1ns / 100ps

module tb_record_timestamp_line_filter_top
  import rtlf_pkg::*;
();

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } out_beat_t;

  class kept_line_scoreboard;
    logic [STAMP_W-1:0] min_stamp;
    logic [7:0]         line_buf [LINE_CAPACITY];
    int unsigned        held;
    bit                 skipping;
    logic [STAMP_W-1:0] stamp;
    int unsigned        digits;
    phase_e             stamp_ph;
    out_beat_t          kept_beats [$];
    int                 errors;

    function new();
      min_stamp = '0;
      errors    = 0;
      clear_line();
    endfunction

    function void clear_line();
      held     = 0;
      skipping = 1'b0;
      stamp    = '0;
      digits   = 0;
      stamp_ph = PH_WAIT;
    endfunction

    function void parse_stamp(int unsigned pos, logic [7:0] b);
      longint unsigned wide;
      if (stamp_ph == PH_WAIT && pos >= PREFIX_LENGTH) stamp_ph = PH_DIGITS;
      if (stamp_ph != PH_DIGITS) return;
      if (b >= CH_ZERO && b <= CH_NINE) begin
        wide  = 64'(stamp) * 64'(RADIX) + 64'(b - CH_ZERO);
        stamp = (wide > 64'hFFFF_FFFF) ? '1 : wide[STAMP_W-1:0];
        if (digits < 127) digits++;
      end else if (b == CH_COMMA) begin
        stamp_ph = (digits > 0) ? PH_VALID : PH_BAD;
      end else begin
        stamp_ph = PH_BAD;
      end
    endfunction

    function void judge_line();
      out_beat_t nb;
      if (!skipping && held > PREFIX_LENGTH && stamp_ph == PH_VALID && stamp >= min_stamp) begin
        for (int i = 0; i < held; i++) begin
          nb.data = line_buf[i];
          nb.last = 1'b0;
          kept_beats.push_back(nb);
        end
        nb.data = CH_NL;
        nb.last = 1'b1;
        kept_beats.push_back(nb);
      end
      clear_line();
    endfunction

    function void take_byte(logic [7:0] b, logic eod);
      if (b == CH_NL) begin
        judge_line();
      end else if (b != CH_CR && !skipping) begin
        if (held < LINE_CAPACITY - 1) begin
          parse_stamp(held, b);
          line_buf[held] = b;
          held++;
        end else begin
          skipping = 1'b1;
          held     = 0;
        end
      end
      if (eod) judge_line();
    endfunction

    task flag_mismatch(string msg);
      errors++;
      $display("%0t ns mismatch: %s", $realtime, msg);
    endtask

    task check_beat(logic [7:0] b, logic last);
      out_beat_t want;
      if (kept_beats.size() == 0) begin
        flag_mismatch($sformatf("unexpected beat %h last %b", b, last));
        return;
      end
      want = kept_beats.pop_front();
      if (b !== want.data)
        flag_mismatch($sformatf("out_byte %h, want %h", b, want.data));
      if (last !== want.last)
        flag_mismatch($sformatf("last_of_run %b, want %b", last, want.last));
    endtask
  endclass

  logic               clk_i;
  logic               rst_ni        = 1'b0;
  logic               cfg_we_i      = 1'b0;
  logic [STAMP_W-1:0] cfg_wdata_i   = '0;
  logic               in_valid_i    = 1'b0;
  logic               in_stall_o;
  logic [7:0]         data_byte_i   = '0;
  logic               end_of_data_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i   = 1'b0;
  logic [7:0]         out_byte_o;
  logic               last_of_run_o;

  kept_line_scoreboard sb = new();
  logic [7:0]          line_q [$];
  bit                  tx_steady = 1'b0;
  bit                  rx_steady = 1'b0;

  record_timestamp_line_filter_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .data_byte_i   (data_byte_i),
    .end_of_data_i (end_of_data_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .last_of_run_o (last_of_run_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (b == CH_NL || b == CH_CR) b = 8'h20;
    return b;
  endfunction

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
  endtask

  task automatic send_beat(input logic [7:0] b, input logic eod);
    int gap;
    if ($urandom_range(0, 39) == 0) tx_steady = !tx_steady;
    gap = tx_steady ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    data_byte_i   <= b;
    end_of_data_i <= eod;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.take_byte(b, eod);
  endtask

  task automatic send_line(input bit eod_last);
    foreach (line_q[i]) send_beat(line_q[i], eod_last && (i == line_q.size() - 1));
    line_q.delete();
  endtask

  // lower valid, let every kept beat drain and the judge cycles settle, then write
  task automatic write_threshold(input logic [STAMP_W-1:0] v);
    in_valid_i <= 1'b0;
    while (sb.kept_beats.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    sb.min_stamp  = v;
  endtask

  task automatic build_random_line(input logic [STAMP_W-1:0] floor_v, input bit force_long,
                                   output bit eod_last);
    int              kind;
    int              tail;
    longint unsigned v;
    string           digs;
    kind = force_long ? 0 : $urandom_range(0, 15);
    eod_last = 1'b0;
    case ($urandom_range(0, 6))
      0:       v = 64'(floor_v);
      1:       v = 64'(floor_v) + $urandom_range(0, 20);
      2:       v = (floor_v > 20) ? 64'(floor_v) - $urandom_range(1, 20) : 64'd0;
      3:       v = 64'($urandom);
      4:       v = 64'd0;
      5:       v = 64'hFFFF_FFFF;
      default: v = {$urandom, $urandom};
    endcase
    digs = $sformatf("%0d", v);
    if ($urandom_range(0, 5) == 0) digs = {"00", digs};
    if (kind == 14) begin
      repeat ($urandom_range(0, PREFIX_LENGTH)) line_q.push_back(text_byte());
    end else if (kind == 15) begin
      repeat ($urandom_range(1, 20)) line_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat (PREFIX_LENGTH) line_q.push_back(text_byte());
      if (kind == 11) begin
        case ($urandom_range(0, 3))
          0:       line_q.push_back("+");
          1:       line_q.push_back("-");
          2:       line_q.push_back(" ");
          default: line_q.push_back("\t");
        endcase
      end
      if (kind != 12) push_text(digs);
      line_q.push_back((kind == 13) ? 8'h78 : CH_COMMA);
      // just past the store: the line overflows by one to three bytes
      tail = force_long ? (LINE_CAPACITY - line_q.size() + $urandom_range(0, 2))
                        : $urandom_range(0, 16);
      repeat (tail) line_q.push_back(text_byte());
      if ($urandom_range(0, 7) == 0) line_q.push_back(CH_CR);
    end
    case ($urandom_range(0, 9))
      0: begin
        line_q.push_back(CH_CR);
        line_q.push_back(CH_NL);
      end
      1: begin
        if (line_q.size() == 0) line_q.push_back(CH_NL);
        eod_last = 1'b1;
      end
      2: begin
        line_q.push_back(CH_NL);
        eod_last = 1'b1;
      end
      default: line_q.push_back(CH_NL);
    endcase
  endtask

  initial begin
    int hold;
    wait (rst_ni);
    forever begin
      if ($urandom_range(0, 39) == 0) rx_steady = !rx_steady;
      hold = rx_steady ? 0 : $urandom_range(0, 16);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (out_valid_o !== 1'b1) @(posedge clk_i);
      sb.check_beat(out_byte_o, last_of_run_o);
    end
  end

  initial begin
    int                 sent;
    bit                 eod;
    logic [STAMP_W-1:0] th;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_threshold('0);

    // extreme bytes in the prefix, CR before the newline
    line_q = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01, CH_ZERO, CH_COMMA, 8'hFE, CH_CR, CH_NL};
    send_line(1'b0);
    push_text("\n");
    send_line(1'b0);
    push_text("ab\n");
    send_line(1'b0);
    push_text("abcde-3,\n");
    send_line(1'b0);
    // saturating stamp, unterminated line flushed by end of data
    push_text("PPPPP99999999999,z");
    send_line(1'b1);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       th = '1;
        1:       th = $urandom;
        2:       th = 32'($urandom_range(0, 5000));
        default: th = '0;
      endcase
      write_threshold(th);
      sent = 0;
      while (sent < 8) begin
        build_random_line(th, (ph == 1) && (sent == 0), eod);
        sent += line_q.size();
        send_line(eod);
      end
    end

    in_valid_i <= 1'b0;
    while (sb.kept_beats.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("PASS record_timestamp_line_filter_top");
    end else begin
      $display("FAIL record_timestamp_line_filter_top");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAIL record_timestamp_line_filter_top");
    $finish;
  end

endmodule

### sim.f
hdl/rtlf_pkg.sv
hdl/rtlf_ctrl.sv
hdl/rtlf_datapath.sv
hdl/record_timestamp_line_filter_top.sv
tb/tb_record_timestamp_line_filter_top.sv
